// File: src/ipmd_pkg.sv
// ipmd_pkg: fixed widths, register indexes and reset values for the
// incremental PID motor drive. No dependencies.
package ipmd_pkg;

  // Fixed field widths
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned DriveW  = 9;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP    = 3'd0,
    REG_GAIN_INTEG   = 3'd1,
    REG_GAIN_DERIV   = 3'd2,
    REG_MAX_FORWARD  = 3'd3,
    REG_MAX_BACKWARD = 3'd4
  } cfg_reg_e;

  // Reset values
  localparam logic [GainW-1:0]  GainPropRst    = 16'd128;
  localparam logic [GainW-1:0]  GainIntegRst   = 16'd77;
  localparam logic [GainW-1:0]  GainDerivRst   = 16'd128;
  localparam logic [LimitW-1:0] MaxForwardRst  = 8'd130;
  localparam logic [LimitW-1:0] MaxBackwardRst = 8'd20;

endpackage

// File: src/incremental_pid_motor_drive.sv
// incremental_pid_motor_drive: top level, input register, PID datapath,
// clamp and result register. Depends on ipmd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one control tick: motor
//   side, target speed and measured encoder speed. Output channel
//   (out_valid_o / out_ready_i) carries one result per tick: side, clamped
//   drive value, forward and backward duty and a clamp flag.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write only while no tick is in flight. Unknown indexes are dropped.
//   Path: after input transfer the tick waits in the input register while one
//   pass of three gain multiplies, sum, truncate and clamp runs into the
//   result register. Throughput: one tick per cycle while results are taken,
//   set by that one datapath pass; the per-side error history is updated as
//   a tick leaves the input register, so a following tick of the same side
//   sees it.
//   Reset: gains and limits return to 0.5 / ~0.3 / 0.5 and 130 / 20, both
//   sides' error histories clear to zero and both stages empty.
//   Stall: while the result is not taken it holds; the input register
//   still takes one more tick, then in_ready_o drops until the output moves.
module incremental_pid_motor_drive
  import ipmd_pkg::*;
#(
  parameter int unsigned SPEED_BITS     = 11,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         side_i,
  input  logic signed [SPEED_BITS-1:0] target_speed_i,
  input  logic signed [SPEED_BITS-1:0] measured_speed_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         side_out_o,
  output logic signed [DriveW-1:0]     drive_value_o,
  output logic [LimitW-1:0]            forward_duty_o,
  output logic [LimitW-1:0]            backward_duty_o,
  output logic                         clamped_o
);

  // Datapath widths follow the speed width and gain format
  localparam int unsigned ErrW  = SPEED_BITS + 1;       // e = target - measured
  localparam int unsigned D1W   = SPEED_BITS + 2;       // e - e1
  localparam int unsigned D2W   = SPEED_BITS + 3;       // e - 2*e1 + e2
  localparam int unsigned ProdW = D2W + GainW + 1;      // signed x unsigned gain
  localparam int unsigned AccW  = ProdW + 2;            // sum of three products
  localparam int unsigned IncW  = AccW - GAIN_FRAC_BITS;
  localparam int unsigned DrvW  = IncW + 1;             // target + increment

  // Configuration registers
  logic [GainW-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [LimitW-1:0] max_forward_q, max_backward_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q    <= GainPropRst;
      gain_integ_q   <= GainIntegRst;
      gain_deriv_q   <= GainDerivRst;
      max_forward_q  <= MaxForwardRst;
      max_backward_q <= MaxBackwardRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_PROP:    gain_prop_q    <= cfg_data_i;
        REG_GAIN_INTEG:   gain_integ_q   <= cfg_data_i;
        REG_GAIN_DERIV:   gain_deriv_q   <= cfg_data_i;
        REG_MAX_FORWARD:  max_forward_q  <= cfg_data_i[LimitW-1:0];
        REG_MAX_BACKWARD: max_backward_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 advances when the result register is free or drains
  logic in_valid_q, out_valid_q;
  logic advance;
  logic in_xfer;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input register
  logic                         side_q;
  logic signed [SPEED_BITS-1:0] target_q, measured_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      side_q     <= side_i;
      target_q   <= target_speed_i;
      measured_q <= measured_speed_i;
    end
  end

  // Per-side error history
  logic signed [ErrW-1:0] err1_q [2];
  logic signed [ErrW-1:0] err2_q [2];

  // PID datapath
  logic signed [ErrW-1:0]  err, e1, e2;
  logic signed [D1W-1:0]   diff1;
  logic signed [D2W-1:0]   diff2;
  logic signed [ErrW:0]    err_x;   // e, one bit wider, into the integral product
  logic signed [ProdW-1:0] prod_p, prod_i, prod_d;
  logic signed [AccW-1:0]  acc, acc_adj;
  logic signed [IncW-1:0]  incr;
  logic signed [DrvW-1:0]  drive, drive_hi, drive_lo, drive_clamp;
  logic                    clip;

  always_comb begin
    e1    = err1_q[side_q];
    e2    = err2_q[side_q];
    err   = ErrW'(target_q) - ErrW'(measured_q);
    err_x = (ErrW + 1)'(err);
    diff1 = D1W'(err) - D1W'(e1);
    diff2 = D2W'(err) - (D2W'(e1) <<< 1) + D2W'(e2);

    prod_p = ProdW'(diff1) * $signed({1'b0, gain_prop_q});
    prod_i = ProdW'(err_x) * $signed({1'b0, gain_integ_q});
    prod_d = ProdW'(diff2) * $signed({1'b0, gain_deriv_q});
    acc    = AccW'(prod_p) + AccW'(prod_i) + AccW'(prod_d);

    // divide by 2^frac, truncating toward zero
    acc_adj = acc[AccW-1]
            ? acc + $signed({{(AccW - GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}})
            : acc;
    incr    = IncW'(acc_adj >>> GAIN_FRAC_BITS);

    drive    = DrvW'(target_q) + DrvW'(incr);
    drive_hi = $signed({{(DrvW - LimitW){1'b0}}, max_forward_q});
    drive_lo = -$signed({{(DrvW - LimitW){1'b0}}, max_backward_q});

    // clip only when strictly outside the limits
    if (drive < drive_lo) begin
      drive_clamp = drive_lo;
      clip        = 1'b1;
    end else if (drive > drive_hi) begin
      drive_clamp = drive_hi;
      clip        = 1'b1;
    end else begin
      drive_clamp = drive;
      clip        = 1'b0;
    end
  end

  // Shift the history of the side whose tick leaves stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err1_q[0] <= '0;
      err1_q[1] <= '0;
      err2_q[0] <= '0;
      err2_q[1] <= '0;
    end else if (advance) begin
      err2_q[side_q] <= e1;
      err1_q[side_q] <= err;
    end
  end

  // Result register
  logic                     side_out_q, clamped_q;
  logic signed [DriveW-1:0] drive_q;
  logic [LimitW-1:0]        fwd_q, bwd_q;
  logic signed [DriveW-1:0] drive_d, drive_neg;

  assign drive_d   = drive_clamp[DriveW-1:0];
  assign drive_neg = -drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      side_out_q <= side_q;
      drive_q    <= drive_d;
      clamped_q  <= clip;
      // negative drive goes to the backward channel as a magnitude
      fwd_q      <= drive_d[DriveW-1] ? '0 : drive_d[LimitW-1:0];
      bwd_q      <= drive_d[DriveW-1] ? drive_neg[LimitW-1:0] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign side_out_o      = side_out_q;
  assign drive_value_o   = drive_q;
  assign forward_duty_o  = fwd_q;
  assign backward_duty_o = bwd_q;
  assign clamped_o       = clamped_q;

endmodule
